[rtl/tmfs_pkg.sv]
package tmfs_pkg;

    // default geometry of the window
    localparam int WINDOW_SIZE_DEF = 15;
    localparam int KEEP_START_DEF  = 5;
    localparam int KEEP_COUNT_DEF  = 5;
    localparam int SAMPLE_BITS_DEF = 10;

    // fixed field widths
    localparam int SUM_W   = 13;
    localparam int THR_W   = 13;
    localparam int DUTY_W  = 8;
    localparam int LEVEL_W = 3;

    localparam logic [SUM_W-1:0] SUM_MAX = 13'd8191;

    // configuration port
    localparam int APB_ADDR_W = 5;
    localparam int APB_DATA_W = 32;
    localparam int REG_IDX_W  = 3;

    typedef logic [REG_IDX_W-1:0] t_reg_idx;

    localparam t_reg_idx REG_FAN_ENABLE   = 3'd0;
    localparam t_reg_idx REG_LOW_THR      = 3'd1;
    localparam t_reg_idx REG_MID_THR      = 3'd2;
    localparam t_reg_idx REG_HIGH_THR     = 3'd3;
    localparam t_reg_idx REG_DUTY_ONE     = 3'd4;
    localparam t_reg_idx REG_DUTY_TWO     = 3'd5;
    localparam t_reg_idx REG_DUTY_THREE   = 3'd6;
    localparam t_reg_idx REG_DUTY_FOUR    = 3'd7;

    // reset values, thresholds in units of the trimmed sum
    localparam logic [THR_W-1:0]  LOW_THR_RST    = 13'd326;
    localparam logic [THR_W-1:0]  MID_THR_RST    = 13'd428;
    localparam logic [THR_W-1:0]  HIGH_THR_RST   = 13'd530;
    localparam logic [DUTY_W-1:0] DUTY_ONE_RST   = 8'd64;
    localparam logic [DUTY_W-1:0] DUTY_TWO_RST   = 8'd128;
    localparam logic [DUTY_W-1:0] DUTY_THREE_RST = 8'd192;
    localparam logic [DUTY_W-1:0] DUTY_FOUR_RST  = 8'd255;

    typedef logic [LEVEL_W-1:0] t_level;

    localparam t_level LEVEL_OFF   = 3'd0;
    localparam t_level LEVEL_ONE   = 3'd1;
    localparam t_level LEVEL_TWO   = 3'd2;
    localparam t_level LEVEL_THREE = 3'd3;
    localparam t_level LEVEL_FOUR  = 3'd4;

    typedef struct packed {
        logic              fan_enable;
        logic [THR_W-1:0]  low_thr;
        logic [THR_W-1:0]  mid_thr;
        logic [THR_W-1:0]  high_thr;
        logic [DUTY_W-1:0] duty_one;
        logic [DUTY_W-1:0] duty_two;
        logic [DUTY_W-1:0] duty_three;
        logic [DUTY_W-1:0] duty_four;
    } t_cfg;

    // result request from the core to the output stage
    typedef struct packed {
        logic             valid;
        logic             off;
        logic [SUM_W-1:0] sum;
    } t_res;

endpackage

[rtl/trimmed_mean_fan_speed_select.sv]
// channel  | handshake                     | payload
// ---------+-------------------------------+------------------------------------
// in       | i_in_valid / o_in_ready       | i_sample
// out      | o_out_valid / i_out_ready     | o_duty, o_speed_level, o_trimmed_sum
// cfg      | i_psel, i_penable, i_pwrite   | i_paddr, i_pwdata, o_prdata, o_pready
//
// a sample that lands in an empty window is written straight into slot zero; any
// other sample is shifted into place, each stored entry larger than it moving up
// one slot (insertion into the window memory, one read and one write per cycle on its two ports)
// the sample that fills the window then has the kept entries summed and the
// result handed to the output register; with fan_enable low a beat skips the
// window, clears the fill count and yields an off result
// synchronous active-low reset clears the fill count and the state; memory
// contents are not cleared, only entries of the current window are ever read
// a full output register stalls the core in its emit step only
module trimmed_mean_fan_speed_select import tmfs_pkg::*; #(
    parameter int WINDOW_SIZE = WINDOW_SIZE_DEF,
    parameter int KEEP_START  = KEEP_START_DEF,
    parameter int KEEP_COUNT  = KEEP_COUNT_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // sample beats
    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    input  logic [SAMPLE_BITS-1:0] i_sample,
    // result beats
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output logic [DUTY_W-1:0]      o_duty,
    output logic [LEVEL_W-1:0]     o_speed_level,
    output logic [SUM_W-1:0]       o_trimmed_sum,
    // register port
    input  logic                   i_psel,
    input  logic                   i_penable,
    input  logic                   i_pwrite,
    input  logic [APB_ADDR_W-1:0]  i_paddr,
    input  logic [APB_DATA_W-1:0]  i_pwdata,
    output logic [APB_DATA_W-1:0]  o_prdata,
    output logic                   o_pready
);

    t_cfg cfg;
    t_res res;
    logic load;

    logic              r_out_valid;
    logic [DUTY_W-1:0] r_duty, n_duty;
    t_level            r_level, n_level;
    logic [SUM_W-1:0]  r_sum;

    // configuration registers, no wait states
    tmfs_regs u_regs (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_psel    (i_psel),
        .i_penable (i_penable),
        .i_pwrite  (i_pwrite),
        .i_paddr   (i_paddr),
        .i_pwdata  (i_pwdata),
        .o_prdata  (o_prdata),
        .o_cfg     (cfg)
    );

    assign o_pready = 1'b1;

    // window collection, sort and trimmed sum
    tmfs_core #(
        .WINDOW_SIZE (WINDOW_SIZE),
        .KEEP_START  (KEEP_START),
        .KEEP_COUNT  (KEEP_COUNT),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_in_valid),
        .i_sample    (i_sample),
        .i_enable    (cfg.fan_enable),
        .o_ready     (o_in_ready),
        .o_res       (res),
        .i_res_ready (load)
    );

    // output register takes a result when empty or being drained
    assign load = res.valid && (!r_out_valid || i_out_ready);

    // band selection, first threshold the sum is below wins
    always_comb begin
        if (res.off) begin
            n_level = LEVEL_OFF;
            n_duty  = '0;
        end else if (res.sum < cfg.low_thr) begin
            n_level = LEVEL_ONE;
            n_duty  = cfg.duty_one;
        end else if (res.sum < cfg.mid_thr) begin
            n_level = LEVEL_TWO;
            n_duty  = cfg.duty_two;
        end else if (res.sum < cfg.high_thr) begin
            n_level = LEVEL_THREE;
            n_duty  = cfg.duty_three;
        end else begin
            n_level = LEVEL_FOUR;
            n_duty  = cfg.duty_four;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
        if (load) begin
            r_duty  <= n_duty;
            r_level <= n_level;
            r_sum   <= res.sum;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_duty        = r_duty;
    assign o_speed_level = r_level;
    assign o_trimmed_sum = r_sum;

`ifndef ASSERT_OFF
    // the off result carries no duty and no sum
    a_off_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_speed_level == LEVEL_OFF) |-> (o_duty == '0) && (o_trimmed_sum == '0))
        else $error("off result with nonzero duty or sum");

    // level stays at off or within the four bands
    a_level_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_speed_level <= LEVEL_FOUR))
        else $error("speed level out of range");

    // a pending core result never overwrites a held beat
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res.valid && o_out_valid && !i_out_ready |=> $stable(o_trimmed_sum) && $stable(o_duty))
        else $error("held result overwritten");

    // the core is never ready while a result is waiting to leave it
    a_core_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res.valid |-> !o_in_ready)
        else $error("core accepts a sample while emitting");
`endif

endmodule

[rtl/tmfs_ram.sv]
module tmfs_ram #(
    parameter int WIDTH = 10,
    parameter int DEPTH = 15
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/tmfs_regs.sv]
module tmfs_regs import tmfs_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_psel,
    input  logic                  i_penable,
    input  logic                  i_pwrite,
    input  logic [APB_ADDR_W-1:0] i_paddr,
    input  logic [APB_DATA_W-1:0] i_pwdata,
    output logic [APB_DATA_W-1:0] o_prdata,
    output t_cfg                  o_cfg
);

    t_cfg     r_cfg;
    t_reg_idx idx;
    logic     wr_en;

    assign idx   = i_paddr[APB_ADDR_W-1:2];
    assign wr_en = i_psel && i_penable && i_pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.fan_enable <= 1'b0;
            r_cfg.low_thr    <= LOW_THR_RST;
            r_cfg.mid_thr    <= MID_THR_RST;
            r_cfg.high_thr   <= HIGH_THR_RST;
            r_cfg.duty_one   <= DUTY_ONE_RST;
            r_cfg.duty_two   <= DUTY_TWO_RST;
            r_cfg.duty_three <= DUTY_THREE_RST;
            r_cfg.duty_four  <= DUTY_FOUR_RST;
        end else if (wr_en) begin
            case (idx)
                REG_FAN_ENABLE: r_cfg.fan_enable <= i_pwdata[0];
                REG_LOW_THR:    r_cfg.low_thr    <= i_pwdata[THR_W-1:0];
                REG_MID_THR:    r_cfg.mid_thr    <= i_pwdata[THR_W-1:0];
                REG_HIGH_THR:   r_cfg.high_thr   <= i_pwdata[THR_W-1:0];
                REG_DUTY_ONE:   r_cfg.duty_one   <= i_pwdata[DUTY_W-1:0];
                REG_DUTY_TWO:   r_cfg.duty_two   <= i_pwdata[DUTY_W-1:0];
                REG_DUTY_THREE: r_cfg.duty_three <= i_pwdata[DUTY_W-1:0];
                REG_DUTY_FOUR:  r_cfg.duty_four  <= i_pwdata[DUTY_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (idx)
            REG_FAN_ENABLE: o_prdata = APB_DATA_W'(r_cfg.fan_enable);
            REG_LOW_THR:    o_prdata = APB_DATA_W'(r_cfg.low_thr);
            REG_MID_THR:    o_prdata = APB_DATA_W'(r_cfg.mid_thr);
            REG_HIGH_THR:   o_prdata = APB_DATA_W'(r_cfg.high_thr);
            REG_DUTY_ONE:   o_prdata = APB_DATA_W'(r_cfg.duty_one);
            REG_DUTY_TWO:   o_prdata = APB_DATA_W'(r_cfg.duty_two);
            REG_DUTY_THREE: o_prdata = APB_DATA_W'(r_cfg.duty_three);
            REG_DUTY_FOUR:  o_prdata = APB_DATA_W'(r_cfg.duty_four);
            default:        o_prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

[rtl/tmfs_core.sv]
module tmfs_core import tmfs_pkg::*; #(
    parameter int WINDOW_SIZE = WINDOW_SIZE_DEF,
    parameter int KEEP_START  = KEEP_START_DEF,
    parameter int KEEP_COUNT  = KEEP_COUNT_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    input  logic [SAMPLE_BITS-1:0] i_sample,
    input  logic                   i_enable,
    output logic                   o_ready,
    output t_res                   o_res,
    input  logic                   i_res_ready
);

    localparam int IDX_W    = $clog2(WINDOW_SIZE);
    localparam int KEEP_END = (KEEP_START + KEEP_COUNT < WINDOW_SIZE) ?
                              (KEEP_START + KEEP_COUNT) : WINDOW_SIZE;
    localparam bit HAS_KEEP = (KEEP_START < WINDOW_SIZE);
    localparam int ACC_RAW  = SAMPLE_BITS + $clog2(KEEP_COUNT) + 1;
    localparam int ACC_W    = (ACC_RAW > SUM_W + 1) ? ACC_RAW : (SUM_W + 1);

    localparam logic [IDX_W-1:0] LAST_FILL  = IDX_W'(WINDOW_SIZE - 1);
    localparam logic [IDX_W-1:0] KEEP_FIRST = IDX_W'(KEEP_START);
    localparam logic [IDX_W-1:0] KEEP_LAST  = IDX_W'(KEEP_END - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SHIFT,
        S_PLACE,
        S_SUM,
        S_SUM_END,
        S_EMIT
    } t_state;

    t_state                 r_state, n_state;
    logic [IDX_W-1:0]       r_fill, n_fill;
    logic [IDX_W-1:0]       r_j, n_j;
    logic [IDX_W-1:0]       r_k, n_k;
    logic [SAMPLE_BITS-1:0] r_key, n_key;
    logic [ACC_W-1:0]       r_acc, n_acc;
    logic                   r_pend, n_pend;
    logic                   r_off, n_off;

    logic                   we;
    logic [IDX_W-1:0]       waddr;
    logic [SAMPLE_BITS-1:0] wdata;
    logic [IDX_W-1:0]       raddr;
    logic [SAMPLE_BITS-1:0] rdata;
    logic                   placed;

    tmfs_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (WINDOW_SIZE)
    ) u_window (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    // insertion sort into the window memory, one shift per cycle, then the trimmed sum and emit; enable low emits off
    always_comb begin
        n_state = r_state;
        n_fill  = r_fill;
        n_j     = r_j;
        n_k     = r_k;
        n_key   = r_key;
        n_acc   = r_acc;
        n_off   = r_off;
        n_pend  = (r_state == S_SUM);
        we      = 1'b0;
        waddr   = r_j;
        wdata   = r_key;
        raddr   = r_k;
        placed  = 1'b0;

        if (r_pend) begin
            n_acc = r_acc + ACC_W'(rdata);
        end

        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    if (!i_enable) begin
                        n_fill  = '0;
                        n_off   = 1'b1;
                        n_state = S_EMIT;
                    end else begin
                        n_key = i_sample;
                        n_off = 1'b0;
                        if (r_fill == '0) begin
                            we     = 1'b1;
                            waddr  = '0;
                            wdata  = i_sample;
                            placed = 1'b1;
                        end else begin
                            raddr   = r_fill - IDX_W'(1);
                            n_j     = r_fill;
                            n_state = S_SHIFT;
                        end
                    end
                end
            end
            S_SHIFT: begin
                we    = 1'b1;
                waddr = r_j;
                if (rdata > r_key) begin
                    wdata = rdata;
                    n_j   = r_j - IDX_W'(1);
                    raddr = r_j - IDX_W'(2);
                    if (r_j == IDX_W'(1)) begin
                        n_state = S_PLACE;
                    end
                end else begin
                    wdata  = r_key;
                    placed = 1'b1;
                end
            end
            S_PLACE: begin
                we     = 1'b1;
                waddr  = '0;
                wdata  = r_key;
                placed = 1'b1;
            end
            S_SUM: begin
                raddr = r_k;
                if (r_k == KEEP_LAST) begin
                    n_state = S_SUM_END;
                end else begin
                    n_k = r_k + IDX_W'(1);
                end
            end
            S_SUM_END: begin
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // after this write, start the sum (or emit) if the window is complete, else advance the fill count
        if (placed) begin
            if (r_fill == LAST_FILL) begin
                n_fill  = '0;
                n_acc   = '0;
                n_k     = KEEP_FIRST;
                n_state = HAS_KEEP ? S_SUM : S_EMIT;
            end else begin
                n_fill  = r_fill + IDX_W'(1);
                n_state = S_IDLE;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_fill  <= '0;
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_fill  <= n_fill;
            r_pend  <= n_pend;
        end
        r_j   <= n_j;
        r_k   <= n_k;
        r_key <= n_key;
        r_acc <= n_acc;
        r_off <= n_off;
    end

    assign o_ready     = (r_state == S_IDLE);
    assign o_res.valid = (r_state == S_EMIT);
    assign o_res.off   = r_off;
    assign o_res.sum   = r_off ? '0 :
                         (r_acc > ACC_W'(SUM_MAX)) ? SUM_MAX : r_acc[SUM_W-1:0];

endmodule
